// ===== rtl/lphm_pkg.sv =====
// lphm_pkg: types, constants and state codes for the linear-probe hash map.
// Used by lphm_ctrl, lphm_dp and the top level under rtl/.
package lphm_pkg;

  localparam int SlotCountDefault = 64;
  localparam int KeyBytesMaxDefault = 31;
  localparam logic [31:0] Djb2Start = 32'd5381;
  localparam logic [6:0] FillLimitReset = 7'd44;
  localparam int KeyWidth = 248;

  typedef enum logic [2:0] {
    ST_UPDATED  = 3'd0,
    ST_INSERTED = 3'd1,
    ST_FULL     = 3'd2,
    ST_FOUND    = 3'd3,
    ST_MISSING  = 3'd4
  } status_t;

  typedef struct packed {
    logic        operation;
    logic [63:0] key_word_0;
    logic [63:0] key_word_1;
    logic [63:0] key_word_2;
    logic [55:0] key_word_3;
    logic [4:0]  key_length;
    logic signed [31:0] new_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] found_value;
  } out_item_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_HASH  = 6'b000010,
    S_READ  = 6'b000100,
    S_CHECK = 6'b001000,
    S_WRITE = 6'b010000,
    S_DONE  = 6'b100000
  } fsm_t;

  typedef struct packed {
    logic load;       // capture item, start hash
    logic hash_step;  // fold one byte
    logic home;       // probe index <- hash
    logic rd;         // issue slot read
    logic advance;    // next slot
    logic wr_value;   // write value only
    logic wr_insert;  // write whole entry
    logic emit;       // present result
  } cmd_t;

  typedef struct packed {
    logic    hash_done;
    logic    slot_valid;
    logic    slot_match;
    logic    lap_done;
    logic    is_get;
    logic    room;
  } sts_t;

endpackage

// ===== rtl/lphm_ram.sv =====
// lphm_ram: generic single-port RAM, registered read.
// No dependencies.
module lphm_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== rtl/lphm_ctrl.sv =====
// lphm_ctrl: sequencer for hash, probe and write-back.
// Depends on lphm_pkg.
module lphm_ctrl import lphm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy
);
  fsm_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        if (sts.hash_done) begin
          cmd.home = 1'b1;
          state_nxt = S_READ;
        end else begin
          cmd.hash_step = 1'b1;
        end
      end
      S_READ: begin
        cmd.rd = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (!sts.slot_valid) begin
          if (!sts.is_get && sts.room) begin
            cmd.wr_insert = 1'b1;
          end
          state_nxt = S_DONE;
        end else if (sts.slot_match) begin
          if (!sts.is_get) cmd.wr_value = 1'b1;
          state_nxt = S_DONE;
        end else if (sts.lap_done) begin
          state_nxt = S_DONE;
        end else begin
          cmd.advance = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_WRITE: state_nxt = S_DONE;
      S_DONE: begin
        cmd.emit = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

// ===== rtl/lphm_dp.sv =====
// lphm_dp: key capture, DJB2 hash, slot store and result register.
// Depends on lphm_pkg and lphm_ram.
module lphm_dp import lphm_pkg::*; #(
  parameter int SlotCount = SlotCountDefault,
  parameter int KeyBytesMax = KeyBytesMaxDefault
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  item,
  input  logic [6:0] fill_limit,
  input  cmd_t      cmd,
  output sts_t      sts,
  output logic      strobe,
  output out_item_t result
);
  localparam int AW = $clog2(SlotCount);
  localparam int EntW = KeyWidth + 5 + 1;
  localparam int CW = $clog2(SlotCount + 1);
  localparam logic [4:0] LenMax = 5'(KeyBytesMax);

  logic [KeyWidth-1:0] key_r;
  logic [4:0] len_r, cnt_r;
  logic op_r;
  logic [31:0] val_r, hash_r;
  logic [AW-1:0] idx_r;
  logic [AW:0] steps_r;
  logic [CW-1:0] count_r;
  logic [SlotCount-1:0] valid_r;
  logic valid_q_r;
  logic [2:0] status_r;
  logic [31:0] found_r;
  logic strobe_r;

  logic [KeyWidth-1:0] key_raw, key_mask;
  logic [4:0] len_sat;
  logic [7:0] byte_now;
  logic [EntW-1:0] ent_rd, ent_wr;
  logic [31:0] val_rd;
  logic ent_we, val_we;
  logic match;

  assign key_raw = {item.key_word_3, item.key_word_2, item.key_word_1, item.key_word_0};
  assign len_sat = (item.key_length > LenMax) ? LenMax : item.key_length;
  always_comb begin
    for (int i = 0; i < KeyWidth / 8; i++) key_mask[i*8 +: 8] = {8{5'(i) < len_sat}};
  end
  assign byte_now = key_r[{cnt_r, 3'b000} +: 8];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r <= key_raw & key_mask;
      len_r <= len_sat;
      op_r  <= item.operation;
      val_r <= item.new_value;
      hash_r <= Djb2Start;
      cnt_r <= '0;
    end else if (cmd.hash_step) begin
      hash_r <= (hash_r << 5) + hash_r + 32'(byte_now);
      cnt_r <= cnt_r + 5'd1;
    end
    if (cmd.home) begin
      idx_r <= hash_r[AW-1:0];
      steps_r <= '0;
    end else if (cmd.advance) begin
      idx_r <= idx_r + AW'(1);
      steps_r <= steps_r + (AW+1)'(1);
    end
    if (cmd.rd) valid_q_r <= valid_r[idx_r];
  end

  assign ent_we = cmd.wr_insert;
  assign val_we = cmd.wr_insert | cmd.wr_value;
  assign ent_wr = {1'b0, len_r, key_r};

  lphm_ram #(.Width(EntW), .Depth(SlotCount)) u_key_ram (
    .clk(clk), .we(ent_we), .addr(idx_r), .wdata(ent_wr), .rdata(ent_rd));
  lphm_ram #(.Width(32), .Depth(SlotCount)) u_val_ram (
    .clk(clk), .we(val_we), .addr(idx_r), .wdata(val_r), .rdata(val_rd));

  assign match = (ent_rd[EntW-2:0] == {len_r, key_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= cmd.emit;
      if (cmd.wr_insert) begin
        valid_r[idx_r] <= 1'b1;
        count_r <= count_r + CW'(1);
      end
    end
  end

  // Outcome decided in the check cycle; value ram output still held then.
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      status_r <= op_r ? ST_MISSING : ST_FULL;
      found_r <= '0;
    end else if (!sts.slot_valid && !cmd.advance && status_r != ST_FOUND &&
                 status_r != ST_UPDATED && status_r != ST_INSERTED && !cmd.emit) begin
      if (!op_r && sts.room) status_r <= ST_INSERTED;
    end else if (valid_q_r && match && !cmd.emit && !cmd.advance &&
                 (status_r == ST_MISSING || status_r == ST_FULL)) begin
      status_r <= op_r ? ST_FOUND : ST_UPDATED;
      found_r <= op_r ? val_rd : 32'd0;
    end
  end

  assign sts.hash_done = (cnt_r == len_r);
  assign sts.slot_valid = valid_q_r;
  assign sts.slot_match = match;
  assign sts.lap_done = (steps_r == (AW+1)'(SlotCount - 1));
  assign sts.is_get = op_r;
  assign sts.room = (32'(count_r) < 32'(fill_limit));

  assign strobe = strobe_r;
  assign result.status = status_r;
  assign result.found_value = found_r;
endmodule

// ===== rtl/linear_probe_hash_map_top.sv =====
// Top level of the linear-probe hash map.
// Depends on lphm_pkg, lphm_ctrl, lphm_dp.
//
// One item at a time: the hash folds one byte a cycle, and each probed slot needs a
// registered RAM read and a compare. A result appears on out_item with out_strobe
// high for one cycle and must be taken then; the receiver cannot stall. busy is
// low when the next start is accepted.
// Slot valid bits reset at once, no clearing pass.
module linear_probe_hash_map_top import lphm_pkg::*; #(
  parameter int SlotCount = SlotCountDefault,
  parameter int KeyBytesMax = KeyBytesMaxDefault
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_strobe,
  output out_item_t out_item,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [6:0] cfg_data
);
  cmd_t cmd;
  sts_t sts;
  logic [6:0] fill_limit_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) fill_limit_r <= FillLimitReset;
    else if (cfg_valid) fill_limit_r <= cfg_data;
  end

  lphm_ctrl u_ctrl (.clk(clk), .rst_n(rst_n), .start(start), .sts(sts), .cmd(cmd),
    .busy(busy));

  lphm_dp #(.SlotCount(SlotCount), .KeyBytesMax(KeyBytesMax)) u_dp (
    .clk(clk), .rst_n(rst_n), .item(in_item), .fill_limit(fill_limit_r), .cmd(cmd),
    .sts(sts), .strobe(out_strobe), .result(out_item));
endmodule

// ===== sim/tb_top.sv =====
// Testbench for linear_probe_hash_map_top: set/get items against an in-bench
// copy of the probing table. Depends on lphm_pkg and the RTL under rtl/.
`timescale 1ns / 1ps
module tb_top;
  import lphm_pkg::*;

  localparam int Slots = 64;
  localparam int MaxLat = 3 + 31 + 2 * Slots + 10;
  localparam int CycleLimit = 600000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_item = '0;
  logic out_strobe;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [6:0] cfg_data = '0;

  linear_probe_hash_map_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // table copy
  logic         tbl_used [Slots];
  logic [247:0] tbl_key [Slots];
  logic [4:0]   tbl_len [Slots];
  logic [31:0]  tbl_val [Slots];
  int           tbl_entries;
  logic [6:0]   fill_limit;

  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  bit        took;
  bit        steady;
  int        errors;
  int        cycles;
  int        status_seen [5];

  // key pool for repeat hits
  logic [247:0] pool_key [80];
  logic [4:0]   pool_len [80];

  function automatic out_item_t probe_table(in_item_t it);
    logic [247:0] k;
    logic [31:0] h;
    int s, n;
    bit hit, hole;
    out_item_t r;
    k = {it.key_word_3, it.key_word_2, it.key_word_1, it.key_word_0};
    h = 32'd5381;
    for (int i = 0; i < 31; i++) begin
      if (i >= it.key_length) k[8*i +: 8] = 8'h00;
      else h = (h << 5) + h + k[8*i +: 8];
    end
    s = h[5:0];
    hit = 0;
    hole = 0;
    for (n = 0; n < Slots; n++) begin
      if (!tbl_used[s]) begin
        hole = 1;
        break;
      end
      if (tbl_len[s] == it.key_length && tbl_key[s] == k) begin
        hit = 1;
        break;
      end
      s = (s + 1) % Slots;
    end
    r.found_value = '0;
    if (it.operation) begin
      r.status = hit ? ST_FOUND : ST_MISSING;
      if (hit) r.found_value = tbl_val[s];
    end else if (hit) begin
      tbl_val[s] = it.new_value;
      r.status = ST_UPDATED;
    end else if (hole && tbl_entries < fill_limit) begin
      tbl_used[s] = 1;
      tbl_key[s] = k;
      tbl_len[s] = it.key_length;
      tbl_val[s] = it.new_value;
      tbl_entries++;
      r.status = ST_INSERTED;
    end else begin
      r.status = ST_FULL;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH @%0t: %s", $time, what);
    errors++;
  endtask

  // sender: drives at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && !took)) begin
      if (pending_items.size() > 0 && (steady || $urandom_range(99) >= 13)) begin
        in_item <= pending_items.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
    took = 0;
  end

  // monitor: accept, predict and check at the rising edge
  always @(posedge clk) begin
    out_item_t want;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
    if (rst_n && start && !busy) begin
      expected_results.push_back(probe_table(in_item));
      took = 1;
    end
    if (rst_n && out_strobe) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = expected_results.pop_front();
        if (out_item.status <= 3'd4) status_seen[out_item.status]++;
        if (out_item.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_item.status, want.status));
        if (out_item.found_value !== want.found_value)
          report_mismatch($sformatf("value %0d, want %0d",
                                    out_item.found_value, want.found_value));
      end
    end
  end

  function automatic in_item_t make_item(bit op, logic [247:0] k, logic [4:0] len,
                                         bit junk);
    in_item_t it;
    logic [247:0] kk;
    kk = k;
    // bytes past the length carry junk when junk is set, which must not count
    for (int i = len; i < 31; i++)
      kk[8*i +: 8] = junk ? 8'($urandom) : 8'h00;
    it.operation = op;
    {it.key_word_3, it.key_word_2, it.key_word_1, it.key_word_0} = kk;
    it.key_length = len;
    it.new_value = $urandom;
    return it;
  endfunction

  function automatic logic [247:0] rand_key();
    logic [247:0] k;
    for (int i = 0; i < 8; i++) k[32*i +: 32] = $urandom;
    return k;
  endfunction

  task automatic add_random(int n);
    int p;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(79);
      if ($urandom_range(9) == 0)
        pending_items.push_back(make_item($urandom_range(1), rand_key(),
                                          5'($urandom_range(31)), 1));
      else
        pending_items.push_back(make_item($urandom_range(1), pool_key[p], pool_len[p],
                                          $urandom_range(1)));
    end
  endtask

  task automatic drain();
    wait (pending_items.size() == 0 && !start && expected_results.size() == 0);
    repeat (MaxLat) @(negedge clk);
  endtask

  task automatic write_fill_limit(logic [6:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    fill_limit = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [247:0] ones;
    for (int s = 0; s < Slots; s++) tbl_used[s] = 0;
    tbl_entries = 0;
    fill_limit = FillLimitReset;
    for (int i = 0; i < 80; i++) begin
      pool_key[i] = rand_key();
      pool_len[i] = (i < 60) ? 5'($urandom_range(1, 6)) : 5'($urandom_range(31));
    end
    ones = '1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty key, longest key, zero byte inside the key, junk past length
    pending_items.push_back(make_item(1, '0, 0, 0));
    pending_items.push_back(make_item(0, '0, 0, 1));
    pending_items.push_back(make_item(1, '0, 0, 1));
    pending_items.push_back(make_item(0, ones, 31, 0));
    pending_items.push_back(make_item(1, ones, 31, 0));
    pending_items.push_back(make_item(0, 248'h4100, 2, 1));
    pending_items.push_back(make_item(1, 248'h4100, 2, 1));
    pending_items.push_back(make_item(1, 248'h41, 1, 1));
    pending_items.push_back(make_item(0, 248'h41, 1, 1));
    pending_items.push_back(make_item(1, 248'h41, 1, 0));
    for (int i = 0; i < 4; i++) begin
      pending_items.push_back(make_item(0, '0, 0, 0));
      pending_items[$].new_value = (i[0]) ? 32'h7fffffff : 32'h80000000;
      pending_items.push_back(make_item(1, '0, 0, 0));
    end
    pending_items.push_back(make_item(0, ones, 31, 0));
    pending_items.push_back(make_item(1, ones, 31, 0));
    drain();

    // default limit, fills to it then rejects
    add_random(140);
    drain();
    write_fill_limit(7'd1);
    add_random(40);
    drain();
    write_fill_limit(7'd0);
    add_random(30);
    drain();
    // no gaps here; fill the whole table so probes lap
    write_fill_limit(7'd127);
    steady = 1;
    for (int i = 0; i < 30; i++)
      pending_items.push_back(make_item(0, rand_key(), 5'($urandom_range(1, 8)), 1));
    add_random(60);
    wait (pending_items.size() == 0);
    steady = 0;
    drain();
    write_fill_limit(7'd64);
    add_random(130);
    drain();

    $display("Ran %0d table entries; updated %0d inserted %0d full %0d found %0d missing %0d",
             tbl_entries, status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4]);
    $display("Fill limits tried: 44, 1, 0, 127, 64");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/lphm_pkg.sv
rtl/lphm_ram.sv
rtl/lphm_ctrl.sv
rtl/lphm_dp.sv
rtl/linear_probe_hash_map_top.sv
sim/tb_top.sv
